[hdl/cfbs_pkg.sv]
`timescale 1ns / 1ps

package cfbs_pkg;

   // Input commands
   typedef enum logic [1:0] {
      CMD_BYTE = 2'd0,
      CMD_TICK = 2'd1,
      CMD_ACK  = 2'd2
   } cmd_type;

   // Result events
   typedef enum logic [2:0] {
      EVT_WAKE_ACC  = 3'd0,
      EVT_PAIR_ACC  = 3'd1,
      EVT_CSUM_ERR  = 3'd2,
      EVT_WAKE_SEND = 3'd3,
      EVT_WAKE_DONE = 3'd4,
      EVT_PAIR_SEND = 3'd5
   } evt_type;

   // Register indexes on the csr port
   typedef enum logic [1:0] {
      CSR_WAKE_DURATION = 2'd0,
      CSR_WAKE_INTERVAL = 2'd1,
      CSR_PAIR_INTERVAL = 2'd2,
      CSR_PAIR_REPEAT   = 2'd3
   } csr_idx_type;

   // Frame constants
   localparam logic [7:0] START_BYTE = 8'hA5;
   localparam logic [7:0] END_BYTE   = 8'h5A;
   localparam logic [7:0] PAIR_TAG   = 8'h10;
   localparam logic [7:0] WAKE_TAG   = 8'h01;
   localparam logic [3:0] LEN_WAKE   = 4'd4;
   localparam logic [3:0] LEN_PAIR   = 4'd14;

   // Register reset values
   localparam logic [15:0] WAKE_DURATION_RST = 16'd15000;
   localparam logic [15:0] WAKE_INTERVAL_RST = 16'd400;
   localparam logic [15:0] PAIR_INTERVAL_RST = 16'd300;
   localparam logic [3:0]  PAIR_REPEAT_RST   = 4'd8;
   localparam logic [15:0] SAT16             = 16'hFFFF;

   typedef struct packed {
      logic [15:0] wake_duration_ms;
      logic [15:0] wake_interval_ms;
      logic [15:0] pair_interval_ms;
      logic [3:0]  pair_repeat_max;
   } cfg_type;

   typedef struct packed {
      logic [31:0] pair_hash;
      logic [31:0] child_ident;
      logic [7:0]  logical_ident;
   } pair_rec_type;

   // Parser result for one byte
   typedef struct packed {
      logic         valid;
      evt_type      event_res;
      pair_rec_type rec;
   } par_evt_type;

   // Broadcast starts raised by the parser
   typedef struct packed {
      logic wake_start;
      logic pair_start;
   } trig_type;

   // Timer results for one tick
   typedef struct packed {
      logic    wake_valid;
      evt_type wake_evt;
      logic    pair_valid;
      logic    pair_final;
   } tick_res_type;

   typedef struct packed {
      evt_type      event_res;
      pair_rec_type rec;
      logic         pair_final;
      logic         last;
   } res_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      sat_inc = (v == SAT16) ? v : v + 16'd1;
   endfunction

endpackage

[hdl/cfbs_req_if.sv]
`timescale 1ns / 1ps

interface cfbs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] rx_byte;

   modport source (output valid, command, rx_byte, input ready);
   modport sink (input valid, command, rx_byte, output ready);
endinterface

[hdl/cfbs_rsp_if.sv]
`timescale 1ns / 1ps

interface cfbs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [31:0] pair_hash;
   logic [31:0] child_ident;
   logic [7:0]  logical_ident;
   logic        pair_final;
   logic        last;

   modport source (output valid, event_res, pair_hash, child_ident, logical_ident,
                   pair_final, last, input ready);
   modport sink (input valid, event_res, pair_hash, child_ident, logical_ident,
                 pair_final, last, output ready);
endinterface

[hdl/command_frame_broadcast_scheduler_unit.sv]
`timescale 1ns / 1ps

// Channel   Role    Payload
// req_if    sink    command, rx_byte
// rsp_if    source  event_res, pair_hash, child_ident, logical_ident, pair_final, last
// csr_*     write   csr_write_enable, csr_index, csr_write_data
//
// An item is decoded in the cycle it is taken and its results land in a two-entry
// result buffer at the same edge: one item per cycle while each gives at most one result
// and rsp_if takes it; a tick that gives two results holds req_if.ready low.
// Reset is synchronous; registers return to their defaults and no results are pending.
// rsp_if stalls hold the buffer; a new item is taken once the buffer's last entry leaves.

module command_frame_broadcast_scheduler_unit #(
   parameter int FRAME_BUFFER_BYTES = 16
) (
   input  logic              clock,
   input  logic              reset,
   cfbs_req_if.sink          req_if,
   cfbs_rsp_if.source        rsp_if,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_write_data
);

   cfbs_pkg::cfg_type      cfg_ff, cfg_in;
   cfbs_pkg::par_evt_type  par_evt;
   cfbs_pkg::trig_type     trig;
   cfbs_pkg::pair_rec_type stored;
   cfbs_pkg::tick_res_type tick_res;
   cfbs_pkg::res_type      res0, res1, out_res;

   logic       accept, can_load, byte_en, tick_en, ack_en;
   logic [1:0] res_count;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            cfbs_pkg::CSR_WAKE_DURATION: cfg_in.wake_duration_ms = csr_write_data;
            cfbs_pkg::CSR_WAKE_INTERVAL: cfg_in.wake_interval_ms = csr_write_data;
            cfbs_pkg::CSR_PAIR_INTERVAL: cfg_in.pair_interval_ms = csr_write_data;
            cfbs_pkg::CSR_PAIR_REPEAT:   cfg_in.pair_repeat_max  = csr_write_data[3:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wake_duration_ms <= cfbs_pkg::WAKE_DURATION_RST;
         cfg_ff.wake_interval_ms <= cfbs_pkg::WAKE_INTERVAL_RST;
         cfg_ff.pair_interval_ms <= cfbs_pkg::PAIR_INTERVAL_RST;
         cfg_ff.pair_repeat_max  <= cfbs_pkg::PAIR_REPEAT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input transfer and command decode
   assign req_if.ready = can_load;
   assign accept  = req_if.valid && can_load;
   assign byte_en = accept && (req_if.command == cfbs_pkg::CMD_BYTE);
   assign tick_en = accept && (req_if.command == cfbs_pkg::CMD_TICK);
   assign ack_en  = accept && (req_if.command == cfbs_pkg::CMD_ACK);

   cfbs_parser #(
      .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .byte_en (byte_en),
      .rx_byte (req_if.rx_byte),
      .par_evt (par_evt),
      .trig    (trig),
      .stored  (stored)
   );

   cfbs_timer u_timer (
      .clock    (clock),
      .reset    (reset),
      .tick_en  (tick_en),
      .ack_en   (ack_en),
      .trig     (trig),
      .cfg      (cfg_ff),
      .tick_res (tick_res)
   );

   // Gather the results of this item, wake result ahead of pair result
   always_comb begin
      res0 = '0;
      res1 = '0;
      res_count = 2'd0;
      res1.event_res  = cfbs_pkg::EVT_PAIR_SEND;
      res1.rec        = stored;
      res1.pair_final = tick_res.pair_final;
      res1.last       = 1'b1;
      if (byte_en) begin
         res0.event_res = par_evt.event_res;
         res0.rec       = par_evt.rec;
         res_count      = {1'b0, par_evt.valid};
      end else if (tick_en) begin
         if (tick_res.wake_valid) begin
            res0.event_res = tick_res.wake_evt;
            res_count      = tick_res.pair_valid ? 2'd2 : 2'd1;
         end else if (tick_res.pair_valid) begin
            res0.event_res  = cfbs_pkg::EVT_PAIR_SEND;
            res0.rec        = stored;
            res0.pair_final = tick_res.pair_final;
            res_count       = 2'd1;
         end
      end
      res0.last = (res_count == 2'd1);
   end

   cfbs_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_count (res_count),
      .res0       (res0),
      .res1       (res1),
      .can_load   (can_load),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .out_res    (out_res)
   );

   assign rsp_if.event_res     = out_res.event_res;
   assign rsp_if.pair_hash     = out_res.rec.pair_hash;
   assign rsp_if.child_ident   = out_res.rec.child_ident;
   assign rsp_if.logical_ident = out_res.rec.logical_ident;
   assign rsp_if.pair_final    = out_res.pair_final;
   assign rsp_if.last          = out_res.last;

endmodule

[hdl/cfbs_parser.sv]
`timescale 1ns / 1ps

module cfbs_parser #(
   parameter int FRAME_BUFFER_BYTES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_en,
   input  logic [7:0]             rx_byte,
   output cfbs_pkg::par_evt_type  par_evt,
   output cfbs_pkg::trig_type     trig,
   output cfbs_pkg::pair_rec_type stored
);

   localparam int IDX_W = $clog2(FRAME_BUFFER_BYTES);
   localparam int CNT_W = $clog2(FRAME_BUFFER_BYTES + 1);

   logic [7:0]             frame_ff [FRAME_BUFFER_BYTES];
   logic [CNT_W-1:0]       index_ff, index_in;
   logic [3:0]             exp_ff, exp_in;
   logic [7:0]             xor_ff, xor_in;
   cfbs_pkg::pair_rec_type stored_ff, stored_in;

   logic                   hunting, take, done, wake_ok, pair_frame, csum_ok;
   logic [CNT_W-1:0]       index_inc;
   logic [3:0]             exp_base, exp_next;
   logic [7:0]             xor_base, xor_next;
   cfbs_pkg::pair_rec_type frame_rec;

   // Frame decode for the current byte
   always_comb begin
      hunting   = (index_ff == '0);
      take      = byte_en && (!hunting || (rx_byte == cfbs_pkg::START_BYTE));
      xor_base  = hunting ? 8'd0 : xor_ff;
      exp_base  = hunting ? 4'd0 : exp_ff;
      index_inc = index_ff + CNT_W'(1);
      xor_next  = (index_ff >= CNT_W'(1) && index_ff <= CNT_W'(11)) ?
                  (xor_base ^ rx_byte) : xor_base;
      if (index_inc == CNT_W'(2)) begin
         exp_next = (rx_byte == cfbs_pkg::WAKE_TAG) ? cfbs_pkg::LEN_WAKE
                                                    : cfbs_pkg::LEN_PAIR;
      end else begin
         exp_next = exp_base;
      end
      done = (exp_next != 4'd0) && (index_inc >= CNT_W'(exp_next));

      wake_ok    = (exp_next == cfbs_pkg::LEN_WAKE) &&
                   (frame_ff[0] == cfbs_pkg::START_BYTE) &&
                   (frame_ff[1] == cfbs_pkg::WAKE_TAG) &&
                   (frame_ff[2] == cfbs_pkg::WAKE_TAG) &&
                   (rx_byte == cfbs_pkg::END_BYTE);
      pair_frame = (exp_next == cfbs_pkg::LEN_PAIR) &&
                   (frame_ff[0] == cfbs_pkg::START_BYTE) &&
                   (frame_ff[2] == cfbs_pkg::PAIR_TAG) &&
                   (rx_byte == cfbs_pkg::END_BYTE);
      csum_ok    = (frame_ff[12] == xor_next);

      frame_rec.pair_hash     = {frame_ff[3], frame_ff[4], frame_ff[5], frame_ff[6]};
      frame_rec.child_ident   = {frame_ff[7], frame_ff[8], frame_ff[9], frame_ff[10]};
      frame_rec.logical_ident = frame_ff[11];

      trig.wake_start = take && done && wake_ok;
      trig.pair_start = take && done && !wake_ok && pair_frame && csum_ok;

      par_evt.valid = take && done && (wake_ok || pair_frame);
      if (wake_ok) begin
         par_evt.event_res = cfbs_pkg::EVT_WAKE_ACC;
      end else if (csum_ok) begin
         par_evt.event_res = cfbs_pkg::EVT_PAIR_ACC;
      end else begin
         par_evt.event_res = cfbs_pkg::EVT_CSUM_ERR;
      end
      par_evt.rec = (!wake_ok && csum_ok) ? frame_rec : '0;

      // Next parser state
      index_in  = index_ff;
      exp_in    = exp_ff;
      xor_in    = xor_ff;
      stored_in = stored_ff;
      if (take) begin
         xor_in = xor_next;
         if (done || index_inc >= CNT_W'(FRAME_BUFFER_BYTES)) begin
            index_in = '0;
            exp_in   = 4'd0;
         end else begin
            index_in = index_inc;
            exp_in   = exp_next;
         end
      end
      if (trig.pair_start) begin
         stored_in = frame_rec;
      end
   end

   // Frame buffer: every byte taken for the current frame
   always_ff @(posedge clock) begin
      if (take) begin
         frame_ff[index_ff[IDX_W-1:0]] <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff  <= '0;
         exp_ff    <= 4'd0;
         xor_ff    <= 8'd0;
         stored_ff <= '0;
      end else begin
         index_ff  <= index_in;
         exp_ff    <= exp_in;
         xor_ff    <= xor_in;
         stored_ff <= stored_in;
      end
   end

   assign stored = stored_ff;

endmodule

[hdl/cfbs_timer.sv]
`timescale 1ns / 1ps

module cfbs_timer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick_en,
   input  logic                   ack_en,
   input  cfbs_pkg::trig_type     trig,
   input  cfbs_pkg::cfg_type      cfg,
   output cfbs_pkg::tick_res_type tick_res
);

   logic        wake_active_ff, wake_active_in;
   logic [15:0] wake_elapsed_ff, wake_elapsed_in;
   logic [15:0] wake_since_ff, wake_since_in;
   logic        pair_active_ff, pair_active_in;
   logic [3:0]  pair_count_ff, pair_count_in;
   logic [15:0] pair_since_ff, pair_since_in;

   logic [15:0] wake_el_inc, wake_si_inc, pair_si_inc;
   logic [3:0]  pair_count_inc;

   always_comb begin
      wake_el_inc    = cfbs_pkg::sat_inc(wake_elapsed_ff);
      wake_si_inc    = cfbs_pkg::sat_inc(wake_since_ff);
      pair_si_inc    = cfbs_pkg::sat_inc(pair_since_ff);
      pair_count_inc = pair_count_ff + 4'd1;

      wake_active_in  = wake_active_ff;
      wake_elapsed_in = wake_elapsed_ff;
      wake_since_in   = wake_since_ff;
      pair_active_in  = pair_active_ff;
      pair_count_in   = pair_count_ff;
      pair_since_in   = pair_since_ff;

      tick_res.wake_valid = 1'b0;
      tick_res.wake_evt   = cfbs_pkg::EVT_WAKE_SEND;
      tick_res.pair_valid = 1'b0;
      tick_res.pair_final = 1'b0;

      // Wake broadcast schedule
      if (tick_en && wake_active_ff) begin
         wake_elapsed_in = wake_el_inc;
         wake_since_in   = wake_si_inc;
         if (wake_el_inc >= cfg.wake_duration_ms) begin
            wake_active_in      = 1'b0;
            tick_res.wake_valid = 1'b1;
            tick_res.wake_evt   = cfbs_pkg::EVT_WAKE_DONE;
         end else if (wake_si_inc >= cfg.wake_interval_ms) begin
            wake_since_in       = 16'd0;
            tick_res.wake_valid = 1'b1;
         end
      end

      // Pair broadcast schedule
      if (tick_en && pair_active_ff && (pair_count_ff < cfg.pair_repeat_max)) begin
         pair_since_in = pair_si_inc;
         if (pair_si_inc >= cfg.pair_interval_ms) begin
            pair_since_in       = 16'd0;
            pair_count_in       = pair_count_inc;
            tick_res.pair_valid = 1'b1;
            tick_res.pair_final = (pair_count_inc >= cfg.pair_repeat_max);
            if (tick_res.pair_final) begin
               pair_active_in = 1'b0;
            end
         end
      end

      if (ack_en) begin
         pair_active_in = 1'b0;
      end

      // Triggers from the parser restart timing
      if (trig.wake_start) begin
         wake_active_in  = 1'b1;
         wake_elapsed_in = 16'd0;
         wake_since_in   = cfbs_pkg::SAT16;
      end
      if (trig.pair_start) begin
         pair_active_in = 1'b1;
         pair_count_in  = 4'd0;
         pair_since_in  = cfbs_pkg::SAT16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wake_active_ff  <= 1'b0;
         wake_elapsed_ff <= 16'd0;
         wake_since_ff   <= cfbs_pkg::SAT16;
         pair_active_ff  <= 1'b0;
         pair_count_ff   <= 4'd0;
         pair_since_ff   <= cfbs_pkg::SAT16;
      end else begin
         wake_active_ff  <= wake_active_in;
         wake_elapsed_ff <= wake_elapsed_in;
         wake_since_ff   <= wake_since_in;
         pair_active_ff  <= pair_active_in;
         pair_count_ff   <= pair_count_in;
         pair_since_ff   <= pair_since_in;
      end
   end

endmodule

[hdl/cfbs_rsp_buf.sv]
`timescale 1ns / 1ps

module cfbs_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [1:0]        load_count,
   input  cfbs_pkg::res_type res0,
   input  cfbs_pkg::res_type res1,
   output logic              can_load,
   output logic              out_valid,
   input  logic              out_ready,
   output cfbs_pkg::res_type out_res
);

   logic [1:0]        count_ff, count_in;
   cfbs_pkg::res_type slot0_ff, slot0_in;
   cfbs_pkg::res_type slot1_ff, slot1_in;

   // Holds the results of one item; drained one transfer at a time
   always_comb begin
      can_load  = (count_ff == 2'd0) || ((count_ff == 2'd1) && out_ready);
      out_valid = (count_ff != 2'd0);
      out_res   = slot0_ff;

      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (out_valid && out_ready) begin
         if (count_ff == 2'd2) begin
            slot0_in = slot1_ff;
            count_in = 2'd1;
         end else begin
            count_in = 2'd0;
         end
      end
      if (load) begin
         slot0_in = res0;
         slot1_in = res1;
         count_in = load_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   // Command code outside the defined set; the block must ignore it
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   localparam int STALL_LIMIT  = 2000;
   localparam int QUIET_CYCLES = 8;
   localparam int PHASE_ITEMS  = 58;
   localparam int PHASE_COUNT  = 6;

   // How a directed row is checked
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_NONE,
      ROW_ONE_EVENT
   } row_kind_type;

   typedef enum logic [1:0] {
      FRAME_GOOD,
      FRAME_BAD_SUM,
      FRAME_BAD_TAG,
      FRAME_BAD_END
   } pair_flavour_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [7:0]        data;
      row_kind_type      kind;
      cfbs_pkg::evt_type ev;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 26;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // nothing active straight after reset
      '{cfbs_pkg::CMD_TICK, 8'h00, ROW_NONE,      cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_ACK,  8'h00, ROW_NONE,      cfbs_pkg::EVT_WAKE_ACC},
      '{CMD_RESERVED,       8'hFF, ROW_NONE,      cfbs_pkg::EVT_WAKE_ACC},
      // bytes outside a frame are dropped
      '{cfbs_pkg::CMD_BYTE, 8'h00, ROW_NONE,      cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'hFF, ROW_NONE,      cfbs_pkg::EVT_WAKE_ACC},
      // wake frame, then the first tick sends at once
      '{cfbs_pkg::CMD_BYTE, 8'hA5, ROW_NONE,      cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'h01, ROW_NONE,      cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'h01, ROW_NONE,      cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'h5A, ROW_ONE_EVENT, cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_TICK, 8'hFF, ROW_ONE_EVENT, cfbs_pkg::EVT_WAKE_SEND},
      // pair frame with a good checksum
      '{cfbs_pkg::CMD_BYTE, 8'hA5, ROW_PREDICT,   cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'h33, ROW_PREDICT,   cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'h10, ROW_PREDICT,   cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'hFF, ROW_PREDICT,   cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'h00, ROW_PREDICT,   cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'h80, ROW_PREDICT,   cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'h01, ROW_PREDICT,   cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'h7F, ROW_PREDICT,   cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'hFE, ROW_PREDICT,   cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'h00, ROW_PREDICT,   cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'hFF, ROW_PREDICT,   cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'hC3, ROW_PREDICT,   cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'hE0, ROW_PREDICT,   cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_BYTE, 8'h5A, ROW_PREDICT,   cfbs_pkg::EVT_WAKE_ACC},
      // pair send on the next tick, then acknowledge
      '{cfbs_pkg::CMD_TICK, 8'h00, ROW_PREDICT,   cfbs_pkg::EVT_WAKE_ACC},
      '{cfbs_pkg::CMD_ACK,  8'hFF, ROW_NONE,      cfbs_pkg::EVT_WAKE_ACC}
   };

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;

   cfbs_req_if req_bus ();
   cfbs_rsp_if rsp_bus ();

   command_frame_broadcast_scheduler_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   int send_idle_pct = 21;
   int recv_idle_pct = 77;
   int mismatch_count = 0;

   // Events the block still owes, oldest first, and those of the current item
   cfbs_pkg::res_type due_events [$];
   cfbs_pkg::res_type step_events [$];

   // Own copy of the scheduler state and registers
   cfbs_pkg::cfg_type      sched_cfg;
   logic [7:0]             frame_buf [16];
   logic [3:0]             byte_pos;
   logic [3:0]             frame_len;
   logic [7:0]             csum_acc;
   logic                   wake_on;
   logic [15:0]            wake_ticks;
   logic [15:0]            wake_gap;
   logic                   pair_on;
   logic [3:0]             pair_count;
   logic [15:0]            pair_gap;
   cfbs_pkg::pair_rec_type held_rec;

   function automatic logic [15:0] bump16(input logic [15:0] v);
      return (&v) ? v : v + 16'd1;
   endfunction

   function automatic cfbs_pkg::res_type make_event(input cfbs_pkg::evt_type ev,
                                                    input logic carry, input logic fin);
      cfbs_pkg::res_type r;
      r = '0;
      r.event_res = ev;
      if (carry) r.rec = held_rec;
      r.pair_final = fin;
      return r;
   endfunction

   task automatic reset_scheduler_model();
      sched_cfg.wake_duration_ms = cfbs_pkg::WAKE_DURATION_RST;
      sched_cfg.wake_interval_ms = cfbs_pkg::WAKE_INTERVAL_RST;
      sched_cfg.pair_interval_ms = cfbs_pkg::PAIR_INTERVAL_RST;
      sched_cfg.pair_repeat_max  = cfbs_pkg::PAIR_REPEAT_RST;
      foreach (frame_buf[i]) frame_buf[i] = 8'h00;
      byte_pos   = 4'd0;
      frame_len  = 4'd0;
      csum_acc   = 8'h00;
      wake_on    = 1'b0;
      wake_ticks = 16'd0;
      wake_gap   = 16'hFFFF;
      pair_on    = 1'b0;
      pair_count = 4'd0;
      pair_gap   = 16'hFFFF;
      held_rec   = '0;
   endtask

   // Frame parser: hunt, collect, then decode a complete frame
   task automatic parse_byte(input logic [7:0] b);
      if (byte_pos == 4'd0 && b != cfbs_pkg::START_BYTE) return;
      if (byte_pos == 4'd0) begin
         frame_len = 4'd0;
         csum_acc  = 8'h00;
      end
      frame_buf[byte_pos] = b;
      if (byte_pos >= 4'd1 && byte_pos <= 4'd11) csum_acc ^= b;
      byte_pos = byte_pos + 4'd1;
      if (byte_pos == 4'd2)
         frame_len = (b == cfbs_pkg::WAKE_TAG) ? cfbs_pkg::LEN_WAKE : cfbs_pkg::LEN_PAIR;

      if (frame_len != 4'd0 && byte_pos >= frame_len) begin
         if (frame_len == cfbs_pkg::LEN_WAKE && frame_buf[0] == cfbs_pkg::START_BYTE &&
             frame_buf[1] == cfbs_pkg::WAKE_TAG && frame_buf[2] == cfbs_pkg::WAKE_TAG &&
             frame_buf[3] == cfbs_pkg::END_BYTE) begin
            wake_on    = 1'b1;
            wake_ticks = 16'd0;
            wake_gap   = 16'hFFFF;
            step_events.push_back(make_event(cfbs_pkg::EVT_WAKE_ACC, 1'b0, 1'b0));
         end else if (frame_len == cfbs_pkg::LEN_PAIR &&
                      frame_buf[0] == cfbs_pkg::START_BYTE &&
                      frame_buf[2] == cfbs_pkg::PAIR_TAG &&
                      frame_buf[13] == cfbs_pkg::END_BYTE) begin
            if (frame_buf[12] != csum_acc) begin
               step_events.push_back(make_event(cfbs_pkg::EVT_CSUM_ERR, 1'b0, 1'b0));
            end else begin
               held_rec.pair_hash     = {frame_buf[3], frame_buf[4], frame_buf[5],
                                         frame_buf[6]};
               held_rec.child_ident   = {frame_buf[7], frame_buf[8], frame_buf[9],
                                         frame_buf[10]};
               held_rec.logical_ident = frame_buf[11];
               pair_on    = 1'b1;
               pair_count = 4'd0;
               pair_gap   = 16'hFFFF;
               step_events.push_back(make_event(cfbs_pkg::EVT_PAIR_ACC, 1'b1, 1'b0));
            end
         end
         byte_pos  = 4'd0;
         frame_len = 4'd0;
      end
   endtask

   // Millisecond tick: wake timing first, then pair timing
   task automatic advance_tick();
      logic fin;
      if (wake_on) begin
         wake_ticks = bump16(wake_ticks);
         wake_gap   = bump16(wake_gap);
         if (wake_ticks >= sched_cfg.wake_duration_ms) begin
            wake_on = 1'b0;
            step_events.push_back(make_event(cfbs_pkg::EVT_WAKE_DONE, 1'b0, 1'b0));
         end else if (wake_gap >= sched_cfg.wake_interval_ms) begin
            wake_gap = 16'd0;
            step_events.push_back(make_event(cfbs_pkg::EVT_WAKE_SEND, 1'b0, 1'b0));
         end
      end
      if (pair_on && pair_count < sched_cfg.pair_repeat_max) begin
         pair_gap = bump16(pair_gap);
         if (pair_gap >= sched_cfg.pair_interval_ms) begin
            pair_gap   = 16'd0;
            pair_count = pair_count + 4'd1;
            fin = (pair_count >= sched_cfg.pair_repeat_max);
            if (fin) pair_on = 1'b0;
            step_events.push_back(make_event(cfbs_pkg::EVT_PAIR_SEND, 1'b1, fin));
         end
      end
   endtask

   task automatic compute_events(input logic [1:0] cmd, input logic [7:0] data);
      step_events.delete();
      case (cmd)
         cfbs_pkg::CMD_BYTE: parse_byte(data);
         cfbs_pkg::CMD_TICK: advance_tick();
         cfbs_pkg::CMD_ACK:  pair_on = 1'b0;
         default:  ;
      endcase
      if (step_events.size() != 0) step_events[step_events.size() - 1].last = 1'b1;
   endtask

   // One input transfer with random idle cycles ahead of it
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                            input row_kind_type kind, input cfbs_pkg::evt_type ev);
      cfbs_pkg::res_type typed;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.rx_byte <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);

      compute_events(cmd, data);
      case (kind)
         ROW_PREDICT: begin
            foreach (step_events[i]) due_events.push_back(step_events[i]);
         end
         ROW_ONE_EVENT: begin
            typed = '0;
            typed.event_res = ev;
            typed.last = 1'b1;
            due_events.push_back(typed);
         end
         default: ;
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(cfbs_pkg::CMD_BYTE, b, ROW_PREDICT, cfbs_pkg::EVT_WAKE_ACC);
   endtask

   task automatic send_pair_frame(input pair_flavour_type flavour);
      logic [7:0] f [14];
      logic [7:0] sum;
      f[0] = cfbs_pkg::START_BYTE;
      f[1] = 8'($urandom);
      if (f[1] == cfbs_pkg::WAKE_TAG) f[1] = 8'h02;
      f[2] = cfbs_pkg::PAIR_TAG;
      for (int k = 3; k < 12; k++) f[k] = 8'($urandom);
      sum = 8'h00;
      for (int k = 1; k < 12; k++) sum ^= f[k];
      f[12] = sum;
      f[13] = cfbs_pkg::END_BYTE;
      case (flavour)
         FRAME_BAD_SUM: f[12] = sum ^ 8'($urandom_range(1, 255));
         FRAME_BAD_TAG: f[2] = cfbs_pkg::PAIR_TAG ^ 8'($urandom_range(1, 255));
         FRAME_BAD_END: f[13] = cfbs_pkg::END_BYTE ^ 8'($urandom_range(1, 255));
         default: ;
      endcase
      for (int k = 0; k < 14; k++) send_byte(f[k]);
   endtask

   // Mostly well-formed frames and tick bursts, some noise and broken frames
   task automatic run_random(input int quota);
      int done_items;
      int pick;
      int burst;
      logic [7:0] x;
      logic [7:0] y;
      done_items = 0;
      while (done_items < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            burst = $urandom_range(1, 20);
            repeat (burst)
               send_item(cfbs_pkg::CMD_TICK, 8'($urandom), ROW_PREDICT,
                         cfbs_pkg::EVT_WAKE_ACC);
            done_items += burst;
         end else if (pick < 55) begin
            send_pair_frame(FRAME_GOOD);
            done_items += 14;
         end else if (pick < 62) begin
            send_pair_frame(FRAME_BAD_SUM);
            done_items += 14;
         end else if (pick < 65) begin
            send_pair_frame(FRAME_BAD_TAG);
            done_items += 14;
         end else if (pick < 68) begin
            send_pair_frame(FRAME_BAD_END);
            done_items += 14;
         end else if (pick < 80) begin
            send_byte(cfbs_pkg::START_BYTE);
            send_byte(cfbs_pkg::WAKE_TAG);
            send_byte(cfbs_pkg::WAKE_TAG);
            send_byte(cfbs_pkg::END_BYTE);
            done_items += 4;
         end else if (pick < 85) begin
            // short frame with the wrong body
            x = 8'($urandom);
            y = 8'($urandom);
            if (x == cfbs_pkg::WAKE_TAG && y == cfbs_pkg::END_BYTE) y = 8'h00;
            send_byte(cfbs_pkg::START_BYTE);
            send_byte(cfbs_pkg::WAKE_TAG);
            send_byte(x);
            send_byte(y);
            done_items += 4;
         end else if (pick < 90) begin
            send_item(cfbs_pkg::CMD_ACK, 8'($urandom), ROW_PREDICT,
                      cfbs_pkg::EVT_WAKE_ACC);
            done_items += 1;
         end else if (pick < 95) begin
            send_byte(8'($urandom));
            done_items += 1;
         end else begin
            send_item(CMD_RESERVED, 8'($urandom), ROW_PREDICT, cfbs_pkg::EVT_WAKE_ACC);
            done_items += 1;
         end
      end
   endtask

   task automatic write_reg(input cfbs_pkg::csr_idx_type idx, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      case (idx)
         cfbs_pkg::CSR_WAKE_DURATION: sched_cfg.wake_duration_ms = value;
         cfbs_pkg::CSR_WAKE_INTERVAL: sched_cfg.wake_interval_ms = value;
         cfbs_pkg::CSR_PAIR_INTERVAL: sched_cfg.pair_interval_ms = value;
         cfbs_pkg::CSR_PAIR_REPEAT:   sched_cfg.pair_repeat_max  = value[3:0];
         default: ;
      endcase
   endtask

   task automatic wait_for_quiet();
      while (due_events.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Result side: random back-pressure and in-order comparison
   initial begin : result_side
      cfbs_pkg::res_type want;
      logic              bad;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (due_events.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result transfer: event %0d hash %h child %h",
                           rsp_bus.event_res, rsp_bus.pair_hash, rsp_bus.child_ident);
               mismatch_count++;
            end else begin
               want = due_events.pop_front();
               bad = (rsp_bus.event_res !== want.event_res) ||
                     (rsp_bus.pair_hash !== want.rec.pair_hash) ||
                     (rsp_bus.child_ident !== want.rec.child_ident) ||
                     (rsp_bus.logical_ident !== want.rec.logical_ident) ||
                     (rsp_bus.pair_final !== want.pair_final) ||
                     (rsp_bus.last !== want.last);
               if (bad) begin
                  if (mismatch_count < 10) begin
                     $display("result mismatch (expected/actual): event %0d/%0d %s",
                              want.event_res, rsp_bus.event_res, "");
                     $display("  hash %h/%h child %h/%h",
                              want.rec.pair_hash, rsp_bus.pair_hash,
                              want.rec.child_ident, rsp_bus.child_ident);
                     $display("  logical %h/%h final %b/%b last %b/%b",
                              want.rec.logical_ident, rsp_bus.logical_ident,
                              want.pair_final, rsp_bus.pair_final,
                              want.last, rsp_bus.last);
                  end
                  mismatch_count++;
               end
            end
         end
         rsp_bus.ready <= reset ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Ends the run when no transfer happens on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      cfbs_pkg::cfg_type plan [PHASE_COUNT];
      req_bus.valid    <= 1'b0;
      req_bus.command  <= cfbs_pkg::CMD_BYTE;
      req_bus.rx_byte  <= 8'h00;
      csr_write_enable <= 1'b0;
      csr_index        <= cfbs_pkg::CSR_WAKE_DURATION;
      csr_write_data   <= 16'd0;
      reset            <= 1'b1;
      reset_scheduler_model();

      // Register settings per phase, the extremes among them
      plan[0] = '{16'd20, 16'd3, 16'd2, 4'd3};
      plan[1] = '{16'd1, 16'd1, 16'd1, 4'd1};
      plan[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15};
      plan[3] = '{16'($urandom_range(5, 60)), 16'($urandom_range(1, 8)),
                  16'($urandom_range(1, 8)), 4'($urandom_range(1, 15))};
      plan[4] = '{16'd40, 16'd1, 16'd1, 4'd15};
      plan[5] = '{16'($urandom_range(2, 30)), 16'($urandom_range(1, 5)),
                  16'($urandom_range(1, 5)), 4'($urandom_range(1, 15))};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows under the reset register values
      for (int r = 0; r < DIRECTED_COUNT; r++)
         send_item(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].data,
                   DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].ev);
      req_bus.valid <= 1'b0;

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         // registers change only once the block has drained
         wait_for_quiet();
         write_reg(cfbs_pkg::CSR_WAKE_DURATION, plan[ph].wake_duration_ms);
         write_reg(cfbs_pkg::CSR_WAKE_INTERVAL, plan[ph].wake_interval_ms);
         write_reg(cfbs_pkg::CSR_PAIR_INTERVAL, plan[ph].pair_interval_ms);
         write_reg(cfbs_pkg::CSR_PAIR_REPEAT, {12'd0, plan[ph].pair_repeat_max});
         csr_write_enable <= 1'b0;
         if (ph < 2) begin
            send_idle_pct = 21;
            recv_idle_pct = 77;
         end else if (ph < 4) begin
            send_idle_pct = 77;
            recv_idle_pct = 21;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         run_random(PHASE_ITEMS);
         req_bus.valid <= 1'b0;
      end

      wait_for_quiet();
      if (mismatch_count == 0 && due_events.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
